>>> rtl/djs_pkg.sv
// ----------------------------------------------------------------------------
// djs_pkg
// Shared constants, state encoding and memory control type of the deadline
// job sequencer.
// ----------------------------------------------------------------------------
package djs_pkg;

    localparam int MAX_JOBS_DEF    = 1024;
    localparam int PROFIT_BITS_DEF = 16;

    localparam int DL_W     = 11;
    localparam int PROF_W   = 16;
    localparam int DONE_W   = 11;
    localparam int TOTAL_W  = 26;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CLEAR,
        S_SCAN,
        S_TAKE,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic job_we;
        logic taken_we;
        logic taken_wd;
        logic slot_we;
        logic slot_wd;
    } t_mem_ctl;

endpackage

>>> rtl/deadline_job_sequencer.sv
// ----------------------------------------------------------------------------
// deadline_job_sequencer
// Loads a set of unit-time jobs and schedules them greedily by falling
// profit into the latest free slot below each deadline; reports the count
// and summed profit of placed jobs and whether any job was dropped as past capacity.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  job     | in        | i_valid / o_stall    | i_job_deadline, i_job_profit,
//          |           |                      | i_last_job
//  result  | out       | o_valid / i_stall    | o_jobs_done, o_total_profit,
//          |           |                      | o_overflow
//
// Jobs load at one per cycle. A last job starts a clearing pass of all MAX_JOBS
// entries, then n rounds, each a scan of the job store, a step to take the best
// job and a read and a check per slot probe until a free slot is found or none
// is left; then a result state. Reset is synchronous and clears the control
// state only. The job channel stalls from the last job until the result is in
// the output register; a result may wait there while the next set loads.
module deadline_job_sequencer #(
    parameter int MAX_JOBS    = djs_pkg::MAX_JOBS_DEF,
    parameter int PROFIT_BITS = djs_pkg::PROFIT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [djs_pkg::DL_W-1:0]    i_job_deadline,
    input  logic [djs_pkg::PROF_W-1:0]  i_job_profit,
    input  logic                        i_last_job,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [djs_pkg::DONE_W-1:0]  o_jobs_done,
    output logic [djs_pkg::TOTAL_W-1:0] o_total_profit,
    output logic                        o_overflow
);

    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int PW = (PROFIT_BITS < djs_pkg::PROF_W) ? PROFIT_BITS : djs_pkg::PROF_W;

    djs_pkg::t_state r_state, n_state;

    logic [CW-1:0]  r_count, n_count;
    logic           r_ovf, n_ovf;
    logic [CW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_round, n_round;
    logic           r_pv, n_pv;
    logic [AW-1:0]  r_pidx, n_pidx;
    logic           r_found, n_found;
    logic [AW-1:0]  r_best, n_best;
    logic [PW-1:0]  r_bprof, n_bprof;
    logic [djs_pkg::DL_W-1:0] r_bdl, n_bdl;
    logic [CW-1:0]  r_slot, n_slot;
    logic [CW-1:0]  r_done, n_done;
    logic [djs_pkg::TOTAL_W-1:0] r_sum, n_sum;
    logic           r_out_valid, n_out_valid;
    logic [djs_pkg::DONE_W-1:0]  r_out_done;
    logic [djs_pkg::TOTAL_W-1:0] r_out_sum;
    logic           r_out_ovf;

    djs_pkg::t_mem_ctl        w_ctl;
    logic [AW-1:0]            w_job_addr;
    logic [AW-1:0]            w_slot_addr;
    logic [djs_pkg::DL_W-1:0] w_rd_dl;
    logic [PW-1:0]            w_rd_pr;
    logic                     w_rd_taken;
    logic                     w_rd_busy;
    logic                     w_in_xfer;
    logic                     w_out_free;
    logic [CW-1:0]            w_sat_dl;
    logic [31:0]              w_done_ext;

    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_sat_dl   = ({21'd0, r_bdl} > 32'(MAX_JOBS)) ? CW'(MAX_JOBS) : CW'(r_bdl);
    assign w_done_ext = 32'(r_done);

    djs_mems #(
        .MAX_JOBS (MAX_JOBS),
        .PW       (PW)
    ) u_mems (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_job_addr  (w_job_addr),
        .i_job_dl    (i_job_deadline),
        .i_job_pr    (i_job_profit[PW-1:0]),
        .i_slot_addr (w_slot_addr),
        .o_job_dl    (w_rd_dl),
        .o_job_pr    (w_rd_pr),
        .o_taken     (w_rd_taken),
        .o_slot_busy (w_rd_busy)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            djs_pkg::S_LOAD: begin
                if (w_in_xfer && i_last_job) n_state = djs_pkg::S_CLEAR;
            end
            djs_pkg::S_CLEAR: begin
                if (r_idx == CW'(MAX_JOBS - 1)) n_state = djs_pkg::S_SCAN;
            end
            djs_pkg::S_SCAN: begin
                if (r_idx == r_count && !r_pv) n_state = djs_pkg::S_TAKE;
            end
            djs_pkg::S_TAKE: begin
                n_state = djs_pkg::S_SLOT_RD;
            end
            djs_pkg::S_SLOT_RD: begin
                if (r_slot == '0) begin
                    n_state = (r_round + 1'b1 == r_count) ? djs_pkg::S_DONE
                                                          : djs_pkg::S_SCAN;
                end else begin
                    n_state = djs_pkg::S_SLOT_CHK;
                end
            end
            djs_pkg::S_SLOT_CHK: begin
                if (!w_rd_busy) begin
                    n_state = (r_round + 1'b1 == r_count) ? djs_pkg::S_DONE
                                                          : djs_pkg::S_SCAN;
                end else begin
                    n_state = djs_pkg::S_SLOT_RD;
                end
            end
            djs_pkg::S_DONE: begin
                if (w_out_free) n_state = djs_pkg::S_LOAD;
            end
            default: n_state = djs_pkg::S_LOAD;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_round     = r_round;
        n_pv        = 1'b0;
        n_pidx      = r_pidx;
        n_found     = r_found;
        n_best      = r_best;
        n_bprof     = r_bprof;
        n_bdl       = r_bdl;
        n_slot      = r_slot;
        n_done      = r_done;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && i_stall;
        w_ctl       = '0;
        w_job_addr  = r_idx[AW-1:0];
        w_slot_addr = r_idx[AW-1:0];
        o_stall     = (r_state != djs_pkg::S_LOAD);
        unique case (r_state)
            djs_pkg::S_LOAD: begin
                w_job_addr = r_count[AW-1:0];
                if (w_in_xfer) begin
                    if (r_count < CW'(MAX_JOBS)) begin
                        w_ctl.job_we = 1'b1;
                        n_count      = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_job) n_idx = '0;
                end
            end
            djs_pkg::S_CLEAR: begin
                // Clear taken and slot marks, one entry a cycle
                w_ctl.taken_we = 1'b1;
                w_ctl.slot_we  = 1'b1;
                n_idx          = r_idx + 1'b1;
                if (r_idx == CW'(MAX_JOBS - 1)) begin
                    n_idx   = '0;
                    n_round = '0;
                    n_found = 1'b0;
                    n_done  = '0;
                    n_sum   = '0;
                end
            end
            djs_pkg::S_SCAN: begin
                // Issue the next read and compare the returned entry
                if (r_idx != r_count) begin
                    n_pv   = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                    n_idx  = r_idx + 1'b1;
                end
                if (r_pv && !w_rd_taken && (!r_found || w_rd_pr > r_bprof)) begin
                    n_found = 1'b1;
                    n_best  = r_pidx;
                    n_bprof = w_rd_pr;
                    n_bdl   = w_rd_dl;
                end
            end
            djs_pkg::S_TAKE: begin
                w_job_addr     = r_best;
                w_ctl.taken_we = 1'b1;
                w_ctl.taken_wd = 1'b1;
                n_slot         = w_sat_dl;
            end
            djs_pkg::S_SLOT_RD: begin
                w_slot_addr = r_slot[AW-1:0] - 1'b1;
                if (r_slot == '0) begin
                    n_round = r_round + 1'b1;
                    n_idx   = '0;
                    n_found = 1'b0;
                end else begin
                    n_slot = r_slot - 1'b1;
                end
            end
            djs_pkg::S_SLOT_CHK: begin
                w_slot_addr = r_slot[AW-1:0];
                if (!w_rd_busy) begin
                    w_ctl.slot_we = 1'b1;
                    w_ctl.slot_wd = 1'b1;
                    n_done  = r_done + 1'b1;
                    n_sum   = r_sum + djs_pkg::TOTAL_W'(r_bprof);
                    n_round = r_round + 1'b1;
                    n_idx   = '0;
                    n_found = 1'b0;
                end
            end
            djs_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= djs_pkg::S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_round <= n_round;
        r_pidx  <= n_pidx;
        r_found <= n_found;
        r_best  <= n_best;
        r_bprof <= n_bprof;
        r_bdl   <= n_bdl;
        r_slot  <= n_slot;
        r_done  <= n_done;
        r_sum   <= n_sum;
    end

    // Load the output register when the result transfers in
    always_ff @(posedge i_clk) begin
        if (r_state == djs_pkg::S_DONE && w_out_free) begin
            r_out_done <= w_done_ext[djs_pkg::DONE_W-1:0];
            r_out_sum  <= r_sum;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_jobs_done    = r_out_done;
    assign o_total_profit = r_out_sum;
    assign o_overflow     = r_out_ovf;

endmodule

>>> rtl/djs_mems.sv
// ----------------------------------------------------------------------------
// djs_mems
// Job store (deadline and profit), taken marks and slot busy marks, each a
// single-port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module djs_mems #(
    parameter int MAX_JOBS = djs_pkg::MAX_JOBS_DEF,
    parameter int PW       = djs_pkg::PROF_W,
    localparam int AW      = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
    input  logic                    i_clk,
    input  djs_pkg::t_mem_ctl       i_ctl,
    input  logic [AW-1:0]           i_job_addr,
    input  logic [djs_pkg::DL_W-1:0] i_job_dl,
    input  logic [PW-1:0]           i_job_pr,
    input  logic [AW-1:0]           i_slot_addr,
    output logic [djs_pkg::DL_W-1:0] o_job_dl,
    output logic [PW-1:0]           o_job_pr,
    output logic                    o_taken,
    output logic                    o_slot_busy
);

    logic [djs_pkg::DL_W+PW-1:0] r_job_mem [MAX_JOBS];
    logic                        r_taken_mem [MAX_JOBS];
    logic                        r_slot_mem [MAX_JOBS];
    logic [djs_pkg::DL_W+PW-1:0] r_job_q;

    // Job store: write on load, read during the selection scan
    always_ff @(posedge i_clk) begin
        if (i_ctl.job_we) begin
            r_job_mem[i_job_addr] <= {i_job_dl, i_job_pr};
        end
        r_job_q <= r_job_mem[i_job_addr];
    end

    assign o_job_dl = r_job_q[djs_pkg::DL_W+PW-1:PW];
    assign o_job_pr = r_job_q[PW-1:0];

    // Taken marks share the job address
    always_ff @(posedge i_clk) begin
        if (i_ctl.taken_we) begin
            r_taken_mem[i_job_addr] <= i_ctl.taken_wd;
        end
        o_taken <= r_taken_mem[i_job_addr];
    end

    // Slot busy marks
    always_ff @(posedge i_clk) begin
        if (i_ctl.slot_we) begin
            r_slot_mem[i_slot_addr] <= i_ctl.slot_wd;
        end
        o_slot_busy <= r_slot_mem[i_slot_addr];
    end

endmodule

>>> verif/deadline_job_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_job_sequencer_tb
// Self-checking bench: loads job sets through the valid/stall channel, works
// out the greedy schedule totals of each set in its own scheduler and checks
// every result transfer against them. A directed table comes first, then
// random sets, including one past capacity, under several idling phases.
// ----------------------------------------------------------------------------
module deadline_job_sequencer_tb;

    localparam int CAP = djs_pkg::MAX_JOBS_DEF;

    typedef struct {
        logic [djs_pkg::DONE_W-1:0]  jobs_done;
        logic [djs_pkg::TOTAL_W-1:0] total_profit;
        logic                        overflow;
    } t_totals;

    typedef struct {
        int      deadline;
        int      profit;
        bit      last;
        bit      typed;
        t_totals want;
    } t_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [djs_pkg::DL_W-1:0]     i_job_deadline;
    logic [djs_pkg::PROF_W-1:0]   i_job_profit;
    logic                         i_last_job;
    logic                         o_valid;
    logic                         i_stall;
    logic [djs_pkg::DONE_W-1:0]   o_jobs_done;
    logic [djs_pkg::TOTAL_W-1:0]  o_total_profit;
    logic                         o_overflow;

    deadline_job_sequencer uut (.*);

    // Scheduler state: jobs of the set being loaded
    int      set_deadline[$];
    int      set_profit[$];
    bit      set_dropped;
    t_totals totals_due[$];

    int      mismatches;
    int      sender_idle_pct;
    int      stall_pct;
    int      hold_cycles;

    t_row    directed_rows[$];

    // Greedy schedule of the loaded set, highest profit first
    function automatic t_totals schedule_totals();
        bit      taken[];
        bit      busy[CAP];
        int      n;
        int      best;
        int      slot;
        longint  cnt;
        longint  sum;
        t_totals res;
        n = set_deadline.size();
        taken = new[n];
        cnt = 0;
        sum = 0;
        foreach (busy[k]) busy[k] = 0;
        for (int r = 0; r < n; r++) begin
            best = -1;
            for (int i = 0; i < n; i++) begin
                if (!taken[i] && (best < 0 || set_profit[i] > set_profit[best])) begin
                    best = i;
                end
            end
            taken[best] = 1;
            slot = (set_deadline[best] > CAP) ? CAP : set_deadline[best];
            while (slot > 0) begin
                slot--;
                if (!busy[slot]) begin
                    busy[slot] = 1;
                    cnt++;
                    sum += set_profit[best];
                    break;
                end
            end
        end
        res.jobs_done    = cnt[djs_pkg::DONE_W-1:0];
        res.total_profit = sum[djs_pkg::TOTAL_W-1:0];
        res.overflow     = set_dropped;
        return res;
    endfunction

    // Record an accepted job; on the last job queue the set's totals
    task automatic record_job(int dl, int pr, bit last, bit typed, t_totals want);
        t_totals got;
        if (set_deadline.size() < CAP) begin
            set_deadline = {set_deadline, dl};
            set_profit   = {set_profit, pr};
        end else begin
            set_dropped = 1;
        end
        if (last) begin
            got = schedule_totals();
            if (typed) got = want;
            totals_due = {totals_due, got};
            set_deadline.delete();
            set_profit.delete();
            set_dropped = 0;
        end
    endtask

    // Offer one job and hold it until transferred
    task automatic send_job(int dl, int pr, bit last, bit typed, t_totals want);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_job_deadline <= dl[djs_pkg::DL_W-1:0];
        i_job_profit   <= pr[djs_pkg::PROF_W-1:0];
        i_last_job     <= last;
        do @(posedge i_clk); while (o_stall);
        record_job(dl, pr, last, typed, want);
    endtask

    task automatic send_set(int size, int dl_max, int pr_max);
        t_totals none;
        int      dl;
        none = '{default: '0};
        for (int j = 0; j < size; j++) begin
            dl = ($urandom_range(15) == 0) ? 1024 : $urandom_range(dl_max);
            send_job(dl, $urandom_range(pr_max, 1), j == size - 1, 0, none);
        end
    endtask

    task automatic random_sets(int jobs);
        int sent;
        int size;
        int pick;
        sent = 0;
        while (sent < jobs) begin
            pick = $urandom_range(9);
            size = (pick == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            case ($urandom_range(3))
                0: send_set(size, 1024, 65535);
                1: send_set(size, size + 2, 4);
                default: send_set(size, size + 2, 65535);
            endcase
            sent += size;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (totals_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Limit
    initial begin
        #200ms;
        $display("simulation failed");
        $finish;
    end

    // Receiver: random stall, or a long hold-off when requested
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Check each result transfer against the oldest due totals
    initial begin
        t_totals want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (totals_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result transfer: got %0d %0d %0d",
                                 o_jobs_done, o_total_profit, o_overflow);
                    end
                end else begin
                    want = totals_due.pop_front();
                    if (o_jobs_done !== want.jobs_done
                        || o_total_profit !== want.total_profit
                        || o_overflow !== want.overflow) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: want done=%0d profit=%0d ovf=%0d got %0d %0d %0d",
                                     want.jobs_done, want.total_profit, want.overflow,
                                     o_jobs_done, o_total_profit, o_overflow);
                        end
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_totals none;
        t_row    row;
        none            = '{default: '0};
        mismatches      = 0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_cycles     = 0;
        set_dropped     = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_job_deadline  = '0;
        i_job_profit    = '0;
        i_last_job      = 1'b0;

        // deadline, profit, last, typed, expected totals
        directed_rows = '{
            '{0,    7,     1, 1, '{0, 0, 0}},
            '{1,    65535, 1, 1, '{1, 65535, 0}},
            '{1024, 1,     1, 1, '{1, 1, 0}},
            '{2,    1,     0, 0, none},
            '{2,    2,     0, 0, none},
            '{2,    3,     1, 1, '{2, 5, 0}},
            '{1,    4,     0, 0, none},
            '{1,    4,     1, 1, '{1, 4, 0}},
            '{0,    65535, 0, 0, none},
            '{1,    10,    0, 0, none},
            '{3,    20,    0, 0, none},
            '{3,    30,    0, 0, none},
            '{2,    40,    1, 0, none},
            '{1024, 65535, 0, 0, none},
            '{1024, 43690, 0, 0, none},
            '{5,    21845, 0, 0, none},
            '{1,    1,     1, 0, none}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            send_job(row.deadline, row.profit, row.last, row.typed, row.want);
        end
        wait_drained();

        // No idling; one set past capacity whose last two jobs are dropped
        for (int j = 0; j < CAP + 2; j++) begin
            send_job($urandom_range(3), $urandom_range(65535, 1), j == CAP + 1, 0, none);
        end
        random_sets(50);

        // Long receiver hold-off while the sender keeps offering sets
        hold_cycles = 20000;
        random_sets(40);
        wait_drained();

        sender_idle_pct = 72;
        stall_pct       = 0;
        random_sets(100);
        sender_idle_pct = 0;
        stall_pct       = 72;
        random_sets(100);
        sender_idle_pct = 37;
        stall_pct       = 37;
        random_sets(100);
        sender_idle_pct = 0;
        stall_pct       = 0;
        random_sets(30);

        // Sender pause until every result is back, then go on
        wait_drained();
        stall_pct = 37;
        random_sets(30);

        wait_drained();
        repeat (2000) @(posedge i_clk);
        if (mismatches == 0 && totals_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/djs_pkg.sv
rtl/djs_mems.sv
rtl/deadline_job_sequencer.sv
verif/deadline_job_sequencer_tb.sv
